[src/mrrc_pkg.sv]
// Shared types, widths and helper functions for the mixed-radix rank converter.
// No dependencies; every other file refers to it by scoped names.
package mrrc_pkg;

  localparam int MAX_DIMS   = 6;
  localparam int NUM_FIELDS = 6;
  localparam int RANK_BITS  = 24;
  localparam int EXT_W      = 13;
  localparam int COORD_W    = 12;
  localparam int DIMS_W     = 3;
  localparam int PROD_W     = RANK_BITS + EXT_W;
  localparam int IDX_W      = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;
  localparam int ADDR_W     = 5;
  localparam int REG_W      = 3;

  localparam logic [EXT_W-1:0]  EXT_MAX  = EXT_W'(4096);
  localparam logic [DIMS_W-1:0] DIMS_MAX = DIMS_W'(MAX_DIMS);

  // Register indexes on the configuration port.
  localparam logic [REG_W-1:0] REG_NUM_DIMS  = REG_W'(0);
  localparam logic [REG_W-1:0] REG_SIZE_BASE = REG_W'(1);

  // Operation codes.
  localparam logic OP_C2R = 1'b0;
  localparam logic OP_R2C = 1'b1;

  typedef logic [NUM_FIELDS-1:0][COORD_W-1:0] coords_t;

  // One word in flight along the chain.
  typedef struct packed {
    logic                 op;
    logic                 err;
    logic [RANK_BITS-1:0] acc;
    logic [EXT_W-1:0]     rem;
    coords_t              coords;
  } word_t;

  function automatic logic [EXT_W-1:0] ext_clamp(input logic [EXT_W-1:0] s);
    logic [EXT_W-1:0] r;
    r = s;
    if (s == '0) r = EXT_W'(1);
    if (s > EXT_MAX) r = EXT_MAX;
    return r;
  endfunction

  function automatic logic [DIMS_W-1:0] dims_clamp(input logic [DIMS_W-1:0] d);
    logic [DIMS_W-1:0] r;
    r = d;
    if (d == '0) r = DIMS_W'(1);
    if (d > DIMS_MAX) r = DIMS_MAX;
    return r;
  endfunction

endpackage

[src/mixed_radix_rank_coordinates.sv]
// Top level of the mixed-radix rank and coordinate converter.
// Depends on mrrc_pkg and mrrc_dim (and through it on the two cell modules).
//
// Converts between a linear rank and row-major grid coordinates, the last
// dimension in use varying fastest. A word enters on every cycle in which
// in_ready_o is high; a new word can be accepted every cycle, so throughput
// is one word per clock while results are taken at the output. The chain is
// built from cells: for each of the six dimensions there are 24 one-bit
// restoring-division cells followed by one closing cell, which holds a
// 24 x 13 multiplier for the rank direction and captures the remainder as a
// coordinate for the other direction. The whole chain advances together and
// stops only while a finished result waits at the output register, so
// in_ready_o follows out_ready_i combinationally. Configuration (number of
// dimensions and each extent) sits on an APB-style port and must only be
// written while no word is in flight. A rank or coordinate outside the grid
// raises range_error_o with the rank and coordinate outputs zero.
module mixed_radix_rank_coordinates (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mrrc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [mrrc_pkg::RANK_BITS-1:0] in_rank_i,
  input  logic [mrrc_pkg::COORD_W-1:0]  coord_in_0_i,
  input  logic [mrrc_pkg::COORD_W-1:0]  coord_in_1_i,
  input  logic [mrrc_pkg::COORD_W-1:0]  coord_in_2_i,
  input  logic [mrrc_pkg::COORD_W-1:0]  coord_in_3_i,
  input  logic [mrrc_pkg::COORD_W-1:0]  coord_in_4_i,
  input  logic [mrrc_pkg::COORD_W-1:0]  coord_in_5_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mrrc_pkg::RANK_BITS-1:0] out_rank_o,
  output logic [mrrc_pkg::COORD_W-1:0]  coord_out_0_o,
  output logic [mrrc_pkg::COORD_W-1:0]  coord_out_1_o,
  output logic [mrrc_pkg::COORD_W-1:0]  coord_out_2_o,
  output logic [mrrc_pkg::COORD_W-1:0]  coord_out_3_o,
  output logic [mrrc_pkg::COORD_W-1:0]  coord_out_4_o,
  output logic [mrrc_pkg::COORD_W-1:0]  coord_out_5_o,
  output logic                          range_error_o
);

  // Configuration registers.
  logic [mrrc_pkg::DIMS_W-1:0] num_dims_q;
  logic [mrrc_pkg::EXT_W-1:0]  size_q [mrrc_pkg::NUM_FIELDS];
  logic [mrrc_pkg::REG_W-1:0]  reg_idx;
  logic                        wr_en;

  assign reg_idx = paddr[mrrc_pkg::ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= mrrc_pkg::DIMS_W'(1);
      for (int i = 0; i < mrrc_pkg::NUM_FIELDS; i++) begin
        size_q[i] <= mrrc_pkg::EXT_W'(1);
      end
    end else if (wr_en) begin
      if (reg_idx == mrrc_pkg::REG_NUM_DIMS) begin
        num_dims_q <= pwdata[mrrc_pkg::DIMS_W-1:0];
      end
      for (int i = 0; i < mrrc_pkg::NUM_FIELDS; i++) begin
        if (reg_idx == mrrc_pkg::REG_SIZE_BASE + mrrc_pkg::REG_W'(i)) begin
          size_q[i] <= pwdata[mrrc_pkg::EXT_W-1:0];
        end
      end
    end
  end

  // Read-back: any index past the list reads as zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == mrrc_pkg::REG_NUM_DIMS) begin
      prdata = 32'(num_dims_q);
    end
    for (int i = 0; i < mrrc_pkg::NUM_FIELDS; i++) begin
      if (reg_idx == mrrc_pkg::REG_SIZE_BASE + mrrc_pkg::REG_W'(i)) begin
        prdata = 32'(size_q[i]);
      end
    end
  end

  // Whole chain advances unless the output register holds an untaken word.
  logic out_valid_q;
  logic en;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  logic [mrrc_pkg::DIMS_W-1:0] dims;
  assign dims = mrrc_pkg::dims_clamp(num_dims_q);

  // Entry word: the rank direction starts from a zero accumulator, the
  // coordinate direction starts with the rank to be divided.
  mrrc_pkg::word_t word_in;
  always_comb begin
    word_in        = '0;
    word_in.op     = operation_i;
    word_in.acc    = (operation_i == mrrc_pkg::OP_R2C) ? in_rank_i : '0;
    word_in.coords[0] = coord_in_0_i;
    word_in.coords[1] = coord_in_1_i;
    word_in.coords[2] = coord_in_2_i;
    word_in.coords[3] = coord_in_3_i;
    word_in.coords[4] = coord_in_4_i;
    word_in.coords[5] = coord_in_5_i;
  end

  logic            vld  [mrrc_pkg::MAX_DIMS+1];
  mrrc_pkg::word_t word [mrrc_pkg::MAX_DIMS+1];

  assign vld[0]  = in_valid_i;
  assign word[0] = word_in;

  // Stage k handles dimension k going towards the rank, and dimension
  // MAX_DIMS-1-k going towards coordinates. Dimensions not in use behave
  // as an extent of one, which leaves both the rank and the remainder alone.
  for (genvar k = 0; k < mrrc_pkg::MAX_DIMS; k++) begin : g_dim
    localparam int D1 = mrrc_pkg::MAX_DIMS - 1 - k;
    logic                       use0, use1;
    logic [mrrc_pkg::EXT_W-1:0] sz0, sz1;

    assign use0 = (mrrc_pkg::DIMS_W'(k)  < dims);
    assign use1 = (mrrc_pkg::DIMS_W'(D1) < dims);
    assign sz0  = use0 ? mrrc_pkg::ext_clamp(size_q[k])  : mrrc_pkg::EXT_W'(1);
    assign sz1  = use1 ? mrrc_pkg::ext_clamp(size_q[D1]) : mrrc_pkg::EXT_W'(1);

    mrrc_dim u_dim (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .vld_i  (vld[k]),
      .word_i (word[k]),
      .sz0_i  (sz0),
      .sz1_i  (sz1),
      .use0_i (use0),
      .idx0_i (mrrc_pkg::IDX_W'(k)),
      .idx1_i (mrrc_pkg::IDX_W'(D1)),
      .vld_o  (vld[k+1]),
      .word_o (word[k+1])
    );
  end

  // Output register. In the coordinate direction any quotient left over
  // means the rank lay beyond the grid.
  mrrc_pkg::word_t              last;
  logic                         err_f;
  logic [mrrc_pkg::RANK_BITS-1:0] rank_d, rank_q;
  mrrc_pkg::coords_t            crd_d, crd_q;
  logic                         err_q;

  assign last   = word[mrrc_pkg::MAX_DIMS];
  assign err_f  = last.err | ((last.op == mrrc_pkg::OP_R2C) & (|last.acc));
  assign rank_d = (err_f || last.op == mrrc_pkg::OP_R2C) ? '0 : last.acc;
  assign crd_d  = (err_f || last.op == mrrc_pkg::OP_C2R) ? '0 : last.coords;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld[mrrc_pkg::MAX_DIMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rank_q <= rank_d;
      crd_q  <= crd_d;
      err_q  <= err_f;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_rank_o    = rank_q;
  assign coord_out_0_o = crd_q[0];
  assign coord_out_1_o = crd_q[1];
  assign coord_out_2_o = crd_q[2];
  assign coord_out_3_o = crd_q[3];
  assign coord_out_4_o = crd_q[4];
  assign coord_out_5_o = crd_q[5];
  assign range_error_o = err_q;

  // An errored word carries nothing but the flag.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |-> (out_rank_o == '0 && crd_q == '0))
    else $error("range error word carries non-zero payload");

  // A word never carries both a rank and coordinates.
  a_one_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rank_o != '0) |-> (crd_q == '0))
    else $error("rank and coordinates both non-zero");

  // The chain stops only while the output word is held.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_rank_o)))
    else $error("held output word changed");

endmodule

[src/mrrc_div_cell.sv]
// One restoring-division bit step of the rank-to-coordinate chain.
// Depends on mrrc_pkg.
module mrrc_div_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  mrrc_pkg::word_t              word_i,
  input  logic [mrrc_pkg::EXT_W-1:0]   sz_i,
  output logic                         vld_o,
  output mrrc_pkg::word_t              word_o
);

  logic [mrrc_pkg::EXT_W-1:0] sh;
  logic                       ge;
  mrrc_pkg::word_t            word_d, word_q;
  logic                       vld_q;

  always_comb begin
    sh     = {word_i.rem[mrrc_pkg::COORD_W-1:0], word_i.acc[mrrc_pkg::RANK_BITS-1]};
    ge     = (sh >= sz_i);
    word_d = word_i;
    if (word_i.op == mrrc_pkg::OP_R2C) begin
      word_d.rem = ge ? (sh - sz_i) : sh;
      word_d.acc = {word_i.acc[mrrc_pkg::RANK_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

[src/mrrc_dim_cell.sv]
// Per-dimension closing cell: multiply-accumulate for coordinates to rank,
// coordinate capture for rank to coordinates. Depends on mrrc_pkg.
module mrrc_dim_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  mrrc_pkg::word_t              word_i,
  input  logic [mrrc_pkg::EXT_W-1:0]   sz0_i,
  input  logic                         use0_i,
  input  logic [mrrc_pkg::IDX_W-1:0]   idx0_i,
  input  logic [mrrc_pkg::IDX_W-1:0]   idx1_i,
  output logic                         vld_o,
  output mrrc_pkg::word_t              word_o
);

  logic [mrrc_pkg::COORD_W-1:0] c;
  logic [mrrc_pkg::PROD_W-1:0]  prod;
  mrrc_pkg::word_t              word_d, word_q;
  logic                         vld_q;

  always_comb begin
    c      = use0_i ? word_i.coords[idx0_i] : '0;
    prod   = mrrc_pkg::PROD_W'(word_i.acc) * mrrc_pkg::PROD_W'(sz0_i)
           + mrrc_pkg::PROD_W'(c);
    word_d = word_i;
    word_d.rem = '0;
    if (word_i.op == mrrc_pkg::OP_C2R) begin
      word_d.acc = prod[mrrc_pkg::RANK_BITS-1:0];
      word_d.err = word_i.err | (mrrc_pkg::EXT_W'(c) >= sz0_i)
                 | (|prod[mrrc_pkg::PROD_W-1:mrrc_pkg::RANK_BITS]);
    end else begin
      word_d.coords[idx1_i] = word_i.rem[mrrc_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign vld_o  = vld_q;
  assign word_o = word_q;

endmodule

[src/mrrc_dim.sv]
// One dimension of the chain: RANK_BITS division cells then a closing cell.
// Depends on mrrc_pkg, mrrc_div_cell and mrrc_dim_cell.
module mrrc_dim (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  mrrc_pkg::word_t              word_i,
  input  logic [mrrc_pkg::EXT_W-1:0]   sz0_i,
  input  logic [mrrc_pkg::EXT_W-1:0]   sz1_i,
  input  logic                         use0_i,
  input  logic [mrrc_pkg::IDX_W-1:0]   idx0_i,
  input  logic [mrrc_pkg::IDX_W-1:0]   idx1_i,
  output logic                         vld_o,
  output mrrc_pkg::word_t              word_o
);

  logic            vld [mrrc_pkg::RANK_BITS+1];
  mrrc_pkg::word_t word[mrrc_pkg::RANK_BITS+1];

  assign vld[0]  = vld_i;
  assign word[0] = word_i;

  for (genvar b = 0; b < mrrc_pkg::RANK_BITS; b++) begin : g_bit
    mrrc_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .vld_i  (vld[b]),
      .word_i (word[b]),
      .sz_i   (sz1_i),
      .vld_o  (vld[b+1]),
      .word_o (word[b+1])
    );
  end

  mrrc_dim_cell u_close (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .vld_i  (vld[mrrc_pkg::RANK_BITS]),
    .word_i (word[mrrc_pkg::RANK_BITS]),
    .sz0_i  (sz0_i),
    .use0_i (use0_i),
    .idx0_i (idx0_i),
    .idx1_i (idx1_i),
    .vld_o  (vld_o),
    .word_o (word_o)
  );

endmodule

[verif/mrrc_checker.sv]
// Checker for the mixed-radix rank converter: watches both word channels,
// predicts each result from its own copy of the grid configuration and compares.
// Depends on mrrc_pkg for widths and operation codes.
module mrrc_checker (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [mrrc_pkg::REG_W-1:0]                  cfg_idx_i,
  input  logic [31:0]                                 cfg_data_i,
  input  logic                                        in_valid_i,
  input  logic                                        in_ready_i,
  input  logic                                        operation_i,
  input  logic [mrrc_pkg::RANK_BITS-1:0]              in_rank_i,
  input  logic [5:0][mrrc_pkg::COORD_W-1:0]           coord_in_i,
  input  logic                                        out_valid_i,
  input  logic                                        out_ready_i,
  input  logic [mrrc_pkg::RANK_BITS-1:0]              out_rank_i,
  input  logic [5:0][mrrc_pkg::COORD_W-1:0]           coord_out_i,
  input  logic                                        range_error_i,
  output int                                          fail_count_o,
  output int                                          pending_o,
  output int                                          checked_o
);

  typedef struct packed {
    logic [mrrc_pkg::RANK_BITS-1:0]    rank;
    logic [5:0][mrrc_pkg::COORD_W-1:0] coords;
    logic                              err;
  } grid_result_t;

  logic [2:0]  dim_count;
  logic [12:0] grid_size [6];
  grid_result_t expected_results [$];

  function automatic grid_result_t convert(input logic op,
                                           input logic [mrrc_pkg::RANK_BITS-1:0] rnk,
                                           input logic [5:0][mrrc_pkg::COORD_W-1:0] cin);
    grid_result_t res;
    int unsigned dims;
    longint unsigned acc, s, cap;
    res = '0;
    cap = 64'd1 << mrrc_pkg::RANK_BITS;
    dims = (dim_count == 0) ? 1 : (dim_count > 6) ? 6 : dim_count;
    acc = 0;
    if (op == mrrc_pkg::OP_C2R) begin
      for (int i = 0; i < dims; i++) begin
        s = (grid_size[i] == 0) ? 1 : (grid_size[i] > 4096) ? 4096 : grid_size[i];
        if (cin[i] >= s) res.err = 1'b1;
        acc = acc * s + cin[i];
        if (acc >= cap) acc = cap;
      end
      if (acc >= cap) res.err = 1'b1;
      res.rank = acc[mrrc_pkg::RANK_BITS-1:0];
    end else begin
      acc = rnk;
      for (int i = dims - 1; i >= 0; i--) begin
        s = (grid_size[i] == 0) ? 1 : (grid_size[i] > 4096) ? 4096 : grid_size[i];
        res.coords[i] = mrrc_pkg::COORD_W'(acc % s);
        acc = acc / s;
      end
      if (acc != 0) res.err = 1'b1;
    end
    if (res.err) begin
      res.rank = '0;
      res.coords = '0;
    end
    return res;
  endfunction

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    grid_result_t got, want;
    if (!rst_ni) begin
      dim_count <= 3'd1;
      for (int i = 0; i < 6; i++) grid_size[i] <= 13'd1;
      expected_results.delete();
      fail_count_o <= 0;
      checked_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == mrrc_pkg::REG_NUM_DIMS) dim_count <= cfg_data_i[2:0];
        else if (cfg_idx_i <= 6)
          grid_size[cfg_idx_i - mrrc_pkg::REG_SIZE_BASE] <= cfg_data_i[12:0];
      end
      if (out_valid_i && out_ready_i) begin
        got = '{rank: out_rank_i, coords: coord_out_i, err: range_error_i};
        checked_o <= checked_o + 1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.rank !== want.rank || got.coords !== want.coords || got.err !== want.err)
          begin
            $display("%0t: mismatch expected rank %h coords %h err %b,",
                     $time, want.rank, want.coords, want.err);
            $display("%0t:          actual rank %h coords %h err %b",
                     $time, got.rank, got.coords, got.err);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        expected_results.insert(expected_results.size(),
                                convert(operation_i, in_rank_i, coord_in_i));
    end
  end
endmodule

[verif/tb_top.sv]
// Testbench top for mixed_radix_rank_coordinates: makes stimulus and configuration
// writes, and gives the verdict. Depends on mrrc_pkg, the block and mrrc_checker.
module tb_top;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [mrrc_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o;
  logic operation_i = mrrc_pkg::OP_C2R;
  logic [mrrc_pkg::RANK_BITS-1:0] in_rank_i = '0;
  logic [5:0][mrrc_pkg::COORD_W-1:0] coord_in = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic [mrrc_pkg::RANK_BITS-1:0] out_rank_o;
  logic [5:0][mrrc_pkg::COORD_W-1:0] coord_out;
  logic range_error_o;
  int fail_count, pending, checked;
  int cycle_count = 0;
  int words_sent = 0;
  bit quiet_stretch = 1'b0;
  logic [12:0] shadow_size [6];
  logic [2:0] shadow_dims;

  localparam int LATENCY = 151;
  localparam int CYCLE_LIMIT = 400000;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  mixed_radix_rank_coordinates i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .operation_i, .in_rank_i,
    .coord_in_0_i(coord_in[0]), .coord_in_1_i(coord_in[1]), .coord_in_2_i(coord_in[2]),
    .coord_in_3_i(coord_in[3]), .coord_in_4_i(coord_in[4]), .coord_in_5_i(coord_in[5]),
    .out_valid_o, .out_ready_i, .out_rank_o,
    .coord_out_0_o(coord_out[0]), .coord_out_1_o(coord_out[1]),
    .coord_out_2_o(coord_out[2]), .coord_out_3_o(coord_out[3]),
    .coord_out_4_o(coord_out[4]), .coord_out_5_o(coord_out[5]),
    .range_error_o
  );

  // The checker sees a register write on the same edge as the block commits it.
  mrrc_checker i_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(psel && penable && pwrite && pready),
    .cfg_idx_i(mrrc_pkg::REG_W'(paddr >> 2)), .cfg_data_i(pwdata),
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .in_rank_i, .coord_in_i(coord_in),
    .out_valid_i(out_valid_o), .out_ready_i, .out_rank_i(out_rank_o),
    .coord_out_i(coord_out), .range_error_i(range_error_o),
    .fail_count_o(fail_count), .pending_o(pending), .checked_o(checked)
  );

  // The watchdog counts every cycle and calls the run off if it drags on.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // The result side stalls about a third of the time, except in quiet stretches.
  always @(posedge clk_i)
    out_ready_i <= quiet_stretch || ($urandom_range(99) >= 33);

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input int idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= mrrc_pkg::ADDR_W'(idx * 4); pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == 0) shadow_dims = value[2:0];
    else if (idx <= 6) shadow_size[idx - 1] = value[12:0];
  endtask

  // Drops the input word, then waits until every expected word has come back,
  // plus the chain's depth.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [2:0] dims, input logic [12:0] s0, s1, s2, s3, s4, s5);
    write_reg(0, 32'(dims));
    write_reg(1, 32'(s0)); write_reg(2, 32'(s1)); write_reg(3, 32'(s2));
    write_reg(4, 32'(s3)); write_reg(5, 32'(s4)); write_reg(6, 32'(s5));
  endtask

  // Presents one word and holds it until the block takes it. Valid drops only
  // during idle cycles, so words can follow each other with no gap.
  task automatic send_word(input logic op, input logic [mrrc_pkg::RANK_BITS-1:0] rnk,
                           input logic [5:0][mrrc_pkg::COORD_W-1:0] crd);
    while (!quiet_stretch && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1; operation_i <= op; in_rank_i <= rnk; coord_in <= crd;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Random but mostly in-grid word: coordinates within the extents, or a rank
  // inside the product, with a minority deliberately out of range or fully random.
  task automatic send_random;
    logic [5:0][mrrc_pkg::COORD_W-1:0] crd;
    longint unsigned prod;
    int unsigned s, dims, pick;
    dims = (shadow_dims == 0) ? 1 : (shadow_dims > 6) ? 6 : shadow_dims;
    prod = 1;
    pick = $urandom_range(9);
    for (int i = 0; i < 6; i++) begin
      s = (shadow_size[i] == 0) ? 1 : (shadow_size[i] > 4096) ? 4096 : shadow_size[i];
      if (i < dims) prod = prod * s;
      crd[i] = (pick < 7) ? mrrc_pkg::COORD_W'($urandom_range(s - 1))
                          : mrrc_pkg::COORD_W'($urandom);
    end
    if (pick == 7) crd[$urandom_range(dims - 1)] = mrrc_pkg::COORD_W'($urandom);
    if ($urandom_range(1) == 0)
      send_word(mrrc_pkg::OP_C2R, mrrc_pkg::RANK_BITS'($urandom), crd);
    else if (pick < 7 && prod <= 64'd16777216)
      send_word(mrrc_pkg::OP_R2C, mrrc_pkg::RANK_BITS'($urandom_range(32'(prod - 1))), crd);
    else send_word(mrrc_pkg::OP_R2C, mrrc_pkg::RANK_BITS'($urandom), crd);
  endtask

  initial begin
    logic [2:0] dims;
    logic [12:0] sz [6];
    for (int i = 0; i < 6; i++) shadow_size[i] = 13'd1;
    shadow_dims = 3'd1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset grid: a single point, so only zero is in range.
    send_word(mrrc_pkg::OP_C2R, '0, '0);
    send_word(mrrc_pkg::OP_R2C, '0, '0);
    send_word(mrrc_pkg::OP_R2C, 24'd1, '1);
    send_word(mrrc_pkg::OP_C2R, '1, {6{12'd1}});
    drain();

    // Zero dimensions and zero extents read as one.
    set_grid(3'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
    send_word(mrrc_pkg::OP_C2R, '0, '0);
    send_word(mrrc_pkg::OP_R2C, 24'd1, '0);
    drain();

    // Six full-size dimensions: extents above the cap clamp to 4096, the rank
    // space overflows, and a coordinate that overflows the rank hits the error path.
    set_grid(3'd7, 13'h1FFF, 13'd4096, 13'd4097, 13'd4096, 13'd4096, 13'd4096);
    send_word(mrrc_pkg::OP_C2R, '0, '0);
    send_word(mrrc_pkg::OP_C2R, '0, {12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0});
    send_word(mrrc_pkg::OP_R2C, '1, '0);
    send_word(mrrc_pkg::OP_R2C, 24'hFFF, '0);
    drain();

    // Two dimensions of 4096: exactly fills the rank space.
    set_grid(3'd2, 13'd4096, 13'd4096, 13'd5, 13'd5, 13'd5, 13'd5);
    send_word(mrrc_pkg::OP_C2R, '0, {12'd0, 12'd0, 12'd0, 12'd0, 12'hFFF, 12'hFFF});
    send_word(mrrc_pkg::OP_C2R, '0, '1);
    send_word(mrrc_pkg::OP_R2C, '1, '0);
    send_word(mrrc_pkg::OP_R2C, 24'h000555, '0);
    send_word(mrrc_pkg::OP_C2R, '0, {12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'hAAA});
    drain();

    // Odd three-dimensional grid with coordinates and ranks on and just past its edge.
    set_grid(3'd3, 13'd3, 13'd7, 13'd5, 13'd1, 13'd1, 13'd1);
    send_word(mrrc_pkg::OP_C2R, '0, {12'd0, 12'd0, 12'd0, 12'd4, 12'd6, 12'd2});
    send_word(mrrc_pkg::OP_C2R, '0, {12'd0, 12'd0, 12'd0, 12'd5, 12'd0, 12'd0});
    send_word(mrrc_pkg::OP_R2C, 24'd104, '0);
    send_word(mrrc_pkg::OP_R2C, 24'd105, '0);
    drain();

    // Random phases, each on a freshly chosen grid; the third runs without idling.
    for (int phase = 0; phase < 10; phase++) begin
      dims = 3'($urandom_range(7));
      for (int i = 0; i < 6; i++) begin
        case ($urandom_range(5))
          0: sz[i] = 13'($urandom);
          1: sz[i] = 13'd4096;
          2: sz[i] = 13'd1;
          default: sz[i] = 13'($urandom_range(1, 40));
        endcase
      end
      if (phase == 9) dims = 3'd6;
      set_grid(dims, sz[0], sz[1], sz[2], sz[3], sz[4], sz[5]);
      quiet_stretch = (phase == 2);
      repeat (175) send_random();
      drain();
    end
    quiet_stretch = 1'b0;

    $display("Converted %0d words over a dozen grid settings, %0d results compared.",
             words_sent, checked);
    $display("Covered both directions, clamped registers and range errors.");
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

[sim.f]
src/mrrc_pkg.sv
src/mrrc_div_cell.sv
src/mrrc_dim_cell.sv
src/mrrc_dim.sv
src/mixed_radix_rank_coordinates.sv
verif/mrrc_checker.sv
verif/tb_top.sv
